### sv/nalsplit_pkg.sv
// Package with the shared types and constants of the Annex B NAL unit splitter.
package nalsplit_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int OUT_BITS = 32;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam int FIFO_DEPTH = 8;

    localparam logic [PADDR_BITS-3:0] REG_CODEC_MODE = 1'b0;

    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_HEVC = 1'b1;

    localparam logic [7:0] START_CODE_LAST = 8'h01;

    typedef enum logic [1:0] {
        HDR_NONE   = 2'd0,
        HDR_FIRST  = 2'd1,
        HDR_SECOND = 2'd2
    } t_hdr_phase;

    typedef struct packed {
        logic [OUT_BITS-1:0] nal_offset;
        logic [OUT_BITS-1:0] nal_size;
        logic [5:0]          nal_type;
        logic [5:0]          layer_id;
        logic signed [3:0]   tid_minus1;
        logic                last_nal;
    } t_nal_rec;

endpackage

### sv/nalsplit_if.sv
// Stream interfaces for the input bytes and the NAL records of the splitter.
interface nalsplit_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

interface nalsplit_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [nalsplit_pkg::OUT_BITS-1:0]    nal_offset;
    logic [nalsplit_pkg::OUT_BITS-1:0]    nal_size;
    logic [5:0]                           nal_type;
    logic [5:0]                           layer_id;
    logic signed [3:0]                    tid_minus1;
    logic                                 last_nal;

    modport source (output valid, output nal_offset, output nal_size, output nal_type,
                    output layer_id, output tid_minus1, output last_nal, input ready);
    modport sink (input valid, input nal_offset, input nal_size, input nal_type,
                  input layer_id, input tid_minus1, input last_nal, output ready);
endinterface

### sv/annexb_nal_unit_splitter.sv
// Top level of the Annex B NAL unit splitter with its APB register and record queue.
//
// Channel   Direction  Beat
// i_in      sink       one stream byte with its end-of-stream flag
// o_out     source     one NAL record: offset, size, header fields, last flag
// APB       slave      codec mode register at byte address 0
//
// One byte is taken per cycle; it is registered, decoded against the parser
// state in the next cycle and its zero, one or two records enter an 8-entry queue.
// The input stalls while the queue holds more than four records, which leaves
// room for the byte in flight and the one being taken.
// Reset is synchronous and active low and clears the parser state and the queue.
module annexb_nal_unit_splitter #(
    parameter int OFFSET_BITS = nalsplit_pkg::OFFSET_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    nalsplit_in_if.sink                           i_in,
    nalsplit_out_if.source                        o_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [nalsplit_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [nalsplit_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [nalsplit_pkg::PDATA_BITS-1:0]   prdata,
    output logic                                  pready
);

    localparam int DEPTH = nalsplit_pkg::FIFO_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    function automatic logic [nalsplit_pkg::OUT_BITS-1:0] sat_out(
        input logic [OFFSET_BITS-1:0] x
    );
        logic [OFFSET_BITS-1:0] lim;
        lim = OFFSET_BITS'(64'h0000_0000_FFFF_FFFF);
        if (x > lim) begin
            sat_out = '1;
        end else begin
            sat_out = nalsplit_pkg::OUT_BITS'(x);
        end
    endfunction

    logic                              r_codec_mode;
    logic                              cfg_wr;
    logic [nalsplit_pkg::PADDR_BITS-3:0] cfg_idx;

    logic                              r_in_valid;
    logic [7:0]                        r_in_byte;
    logic                              r_in_end;

    logic [OFFSET_BITS-1:0]            r_pos, n_pos;
    logic [1:0]                        r_zrun, n_zrun;
    logic                              r_pend, n_pend;
    logic [OFFSET_BITS-1:0]            r_poff, n_poff;
    logic [5:0]                        r_ptype, n_ptype;
    logic [5:0]                        r_player, n_player;
    logic [3:0]                        r_ptemp, n_ptemp;
    nalsplit_pkg::t_hdr_phase          r_hphase, n_hphase;

    nalsplit_pkg::t_nal_rec            r_fifo [DEPTH];
    logic [PTR_BITS-1:0]               r_wr, r_rd;
    logic [CNT_BITS-1:0]               r_cnt;

    logic                              start_hit;
    logic [OFFSET_BITS-1:0]            start_pos;
    logic [OFFSET_BITS-1:0]            stream_len;
    logic                              push_a, push_b;
    nalsplit_pkg::t_nal_rec            rec_a, rec_b, wr0_rec;
    logic [1:0]                        n_push;
    logic                              pop;
    logic [5:0]                        h_type, h_layer;
    logic [3:0]                        h_temp;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[nalsplit_pkg::PADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (cfg_idx == nalsplit_pkg::REG_CODEC_MODE);

    always_comb begin
        prdata = '0;
        if (cfg_idx == nalsplit_pkg::REG_CODEC_MODE) begin
            prdata[0] = r_codec_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec_mode <= nalsplit_pkg::CODEC_H264;
        end else if (cfg_wr) begin
            r_codec_mode <= pwdata[0];
        end
    end

    // Input register.
    assign i_in.ready = (r_cnt <= CNT_BITS'(DEPTH - 4));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in.valid && i_in.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_end  <= i_in.stream_end;
        end
    end

    // Header phase sequencing.
    always_comb begin
        if (start_hit) begin
            n_hphase = nalsplit_pkg::HDR_FIRST;
        end else begin
            case (r_hphase)
                nalsplit_pkg::HDR_FIRST: n_hphase = nalsplit_pkg::HDR_SECOND;
                default:                 n_hphase = nalsplit_pkg::HDR_NONE;
            endcase
        end
        if (r_in_end) begin
            n_hphase = nalsplit_pkg::HDR_NONE;
        end
    end

    // Parser datapath for the registered byte.
    always_comb begin
        h_type  = r_ptype;
        h_layer = r_player;
        h_temp  = r_ptemp;
        case (r_hphase)
            nalsplit_pkg::HDR_FIRST: begin
                if (r_codec_mode == nalsplit_pkg::CODEC_HEVC) begin
                    h_type  = r_in_byte[6:1];
                    h_layer = {r_in_byte[0], 5'd0};
                    h_temp  = 4'hf;
                end else begin
                    h_type  = {1'b0, r_in_byte[4:0]};
                    h_layer = 6'd0;
                    h_temp  = 4'd0;
                end
            end
            nalsplit_pkg::HDR_SECOND: begin
                if (r_codec_mode == nalsplit_pkg::CODEC_HEVC) begin
                    h_layer = {r_player[5], r_in_byte[7:3]};
                    h_temp  = {1'b0, r_in_byte[2:0]} - 4'd1;
                end
            end
            default: begin
                h_type = r_ptype;
            end
        endcase

        start_hit = (r_in_byte == nalsplit_pkg::START_CODE_LAST) && (r_zrun >= 2'd2);
        start_pos = r_pos - OFFSET_BITS'(2) - OFFSET_BITS'(r_zrun == 2'd3);
        stream_len = (r_pos != POS_MAX) ? r_pos + OFFSET_BITS'(1) : POS_MAX;

        rec_a.nal_offset  = sat_out(r_poff);
        rec_a.nal_size    = sat_out((start_pos > r_poff) ? start_pos - r_poff : '0);
        rec_a.nal_type    = h_type;
        rec_a.layer_id    = h_layer;
        rec_a.tid_minus1  = h_temp;
        rec_a.last_nal    = 1'b0;
        push_a = r_in_valid && start_hit && r_pend;

        n_pend   = r_pend;
        n_poff   = r_poff;
        n_ptype  = h_type;
        n_player = h_layer;
        n_ptemp  = h_temp;
        if (start_hit) begin
            n_pend   = 1'b1;
            n_poff   = start_pos;
            n_ptype  = 6'd0;
            n_player = 6'd0;
            n_ptemp  = (r_codec_mode == nalsplit_pkg::CODEC_HEVC) ? 4'hf : 4'd0;
        end

        rec_b.nal_offset  = sat_out(n_poff);
        rec_b.nal_size    = sat_out((stream_len > n_poff) ? stream_len - n_poff : '0);
        rec_b.nal_type    = n_ptype;
        rec_b.layer_id    = n_player;
        rec_b.tid_minus1  = n_ptemp;
        rec_b.last_nal    = 1'b1;
        push_b = r_in_valid && r_in_end && n_pend;

        if (r_in_byte == 8'd0) begin
            n_zrun = (r_zrun != 2'd3) ? r_zrun + 2'd1 : 2'd3;
        end else begin
            n_zrun = 2'd0;
        end

        if (r_in_end) begin
            n_pos    = '0;
            n_zrun   = 2'd0;
            n_pend   = 1'b0;
            n_poff   = '0;
            n_ptype  = 6'd0;
            n_player = 6'd0;
            n_ptemp  = 4'd0;
        end else begin
            n_pos = (r_pos != POS_MAX) ? r_pos + OFFSET_BITS'(1) : POS_MAX;
        end

        wr0_rec = push_a ? rec_a : rec_b;
        n_push  = {1'b0, push_a} + {1'b0, push_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_zrun   <= 2'd0;
            r_pend   <= 1'b0;
            r_poff   <= '0;
            r_ptype  <= 6'd0;
            r_player <= 6'd0;
            r_ptemp  <= 4'd0;
            r_hphase <= nalsplit_pkg::HDR_NONE;
        end else if (r_in_valid) begin
            r_pos    <= n_pos;
            r_zrun   <= n_zrun;
            r_pend   <= n_pend;
            r_poff   <= n_poff;
            r_ptype  <= n_ptype;
            r_player <= n_player;
            r_ptemp  <= n_ptemp;
            r_hphase <= n_hphase;
        end
    end

    // Record queue.
    assign pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (push_a || push_b) begin
            r_fifo[r_wr] <= wr0_rec;
        end
        if (push_a && push_b) begin
            r_fifo[r_wr + PTR_BITS'(1)] <= rec_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_BITS'(n_push);
            r_rd  <= r_rd + PTR_BITS'(pop);
            r_cnt <= r_cnt + CNT_BITS'(n_push) - CNT_BITS'(pop);
        end
    end

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.nal_offset  = r_fifo[r_rd].nal_offset;
    assign o_out.nal_size    = r_fifo[r_rd].nal_size;
    assign o_out.nal_type    = r_fifo[r_rd].nal_type;
    assign o_out.layer_id    = r_fifo[r_rd].layer_id;
    assign o_out.tid_minus1  = r_fifo[r_rd].tid_minus1;
    assign o_out.last_nal    = r_fifo[r_rd].last_nal;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(DEPTH))
        else $error("Record queue count exceeds its depth.");

    a_room_for_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (r_cnt <= CNT_BITS'(DEPTH - 2)))
        else $error("Byte in flight without room for its records.");

    a_byte_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_in_valid)
        else $error("Accepted byte did not reach the input register.");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_codec_mode == $past(pwdata[0])))
        else $error("Codec mode write was lost.");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the Annex B NAL unit splitter with its own record predictor.
`timescale 1ns / 100ps

module testbench;

    class nal_record_predictor;
        logic                      codec_mode;
        logic [31:0]               byte_pos;
        logic [1:0]                zero_run;
        logic                      nal_open;
        logic [31:0]               open_offset;
        logic [5:0]                open_type;
        logic [5:0]                open_layer;
        logic [3:0]                open_temporal;
        nalsplit_pkg::t_hdr_phase  hdr_phase;
        nalsplit_pkg::t_nal_rec    expected_nals[$];
        int                        bytes_taken;
        int                        streams_ended;
        int                        nals_checked;
        int                        mismatches;

        function new();
            codec_mode = nalsplit_pkg::CODEC_H264;
            bytes_taken = 0;
            streams_ended = 0;
            nals_checked = 0;
            mismatches = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            byte_pos = '0;
            zero_run = '0;
            nal_open = 1'b0;
            open_offset = '0;
            open_type = '0;
            open_layer = '0;
            open_temporal = '0;
            hdr_phase = nalsplit_pkg::HDR_NONE;
        endfunction

        function void emit_nal(logic [31:0] end_pos, logic last);
            nalsplit_pkg::t_nal_rec rec;
            rec.nal_offset = open_offset;
            rec.nal_size = (end_pos > open_offset) ? end_pos - open_offset : '0;
            rec.nal_type = open_type;
            rec.layer_id = open_layer;
            rec.tid_minus1 = open_temporal;
            rec.last_nal = last;
            expected_nals.insert(expected_nals.size(), rec);
        endfunction

        function void take_byte(logic [7:0] b, logic stream_end);
            logic [31:0] pos;
            logic [31:0] start;
            pos = byte_pos;
            bytes_taken++;
            case (hdr_phase)
                nalsplit_pkg::HDR_FIRST: begin
                    if (codec_mode == nalsplit_pkg::CODEC_HEVC) begin
                        open_type = b[6:1];
                        open_layer = {b[0], 5'd0};
                        open_temporal = 4'hf;
                    end else begin
                        open_type = {1'b0, b[4:0]};
                        open_layer = '0;
                        open_temporal = '0;
                    end
                    hdr_phase = nalsplit_pkg::HDR_SECOND;
                end
                nalsplit_pkg::HDR_SECOND: begin
                    if (codec_mode == nalsplit_pkg::CODEC_HEVC) begin
                        open_layer = {open_layer[5], b[7:3]};
                        open_temporal = {1'b0, b[2:0]} - 4'd1;
                    end
                    hdr_phase = nalsplit_pkg::HDR_NONE;
                end
                default: hdr_phase = nalsplit_pkg::HDR_NONE;
            endcase

            if (b == nalsplit_pkg::START_CODE_LAST && zero_run >= 2) begin
                start = pos - 32'd2 - ((zero_run == 2'd3) ? 32'd1 : 32'd0);
                if (nal_open) begin
                    emit_nal(start, 1'b0);
                end
                nal_open = 1'b1;
                open_offset = start;
                open_type = '0;
                open_layer = '0;
                open_temporal = (codec_mode == nalsplit_pkg::CODEC_HEVC) ? 4'hf : 4'h0;
                hdr_phase = nalsplit_pkg::HDR_FIRST;
            end

            if (b == 8'h00) begin
                zero_run = (zero_run == 2'd3) ? 2'd3 : zero_run + 2'd1;
            end else begin
                zero_run = '0;
            end

            if (stream_end) begin
                if (nal_open) begin
                    emit_nal((pos == 32'hffff_ffff) ? pos : pos + 32'd1, 1'b1);
                end
                streams_ended++;
                clear_stream();
            end else if (pos != 32'hffff_ffff) begin
                byte_pos = pos + 32'd1;
            end
        endfunction

        function void report(string what, nalsplit_pkg::t_nal_rec want,
                             nalsplit_pkg::t_nal_rec got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR %s at %0t", what, $time);
                $display("  expected off=%0d size=%0d type=%0d layer=%0d tid=%0d last=%0b",
                         want.nal_offset, want.nal_size, want.nal_type, want.layer_id,
                         want.tid_minus1, want.last_nal);
                $display("  actual   off=%0d size=%0d type=%0d layer=%0d tid=%0d last=%0b",
                         got.nal_offset, got.nal_size, got.nal_type, got.layer_id,
                         got.tid_minus1, got.last_nal);
            end
        endfunction

        function void check_nal(nalsplit_pkg::t_nal_rec got);
            nalsplit_pkg::t_nal_rec want;
            nals_checked++;
            if (expected_nals.size() == 0) begin
                want = '0;
                report("NAL record with none expected", want, got);
            end else begin
                want = expected_nals.pop_front();
                if (got.nal_offset !== want.nal_offset || got.nal_size !== want.nal_size ||
                    got.nal_type !== want.nal_type || got.layer_id !== want.layer_id ||
                    got.tid_minus1 !== want.tid_minus1 || got.last_nal !== want.last_nal) begin
                    report("NAL record mismatch", want, got);
                end
            end
        endfunction
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [nalsplit_pkg::PADDR_BITS-1:0]  paddr;
    logic [nalsplit_pkg::PDATA_BITS-1:0]  pwdata;
    logic [nalsplit_pkg::PDATA_BITS-1:0]  prdata;
    logic                                 pready;

    nalsplit_in_if  in_bus();
    nalsplit_out_if out_bus();

    nal_record_predictor nal_model;
    int send_idle_pct;
    int recv_stall_pct;
    int mode_writes;

    annexb_nal_unit_splitter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        nalsplit_pkg::t_nal_rec got;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.nal_offset = out_bus.nal_offset;
            got.nal_size = out_bus.nal_size;
            got.nal_type = out_bus.nal_type;
            got.layer_id = out_bus.layer_id;
            got.tid_minus1 = out_bus.tid_minus1;
            got.last_nal = out_bus.last_nal;
            nal_model.check_nal(got);
        end
    end

    task automatic send_byte(logic [7:0] b, logic stream_end);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_bus.valid <= 1'b1;
        in_bus.data_byte <= b;
        in_bus.stream_end <= stream_end;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        nal_model.take_byte(b, stream_end);
    endtask

    task automatic wait_all_nals();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (nal_model.expected_nals.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_codec_mode(logic mode);
        wait_all_nals();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {nalsplit_pkg::REG_CODEC_MODE, 2'b00};
        pwdata <= {{(nalsplit_pkg::PDATA_BITS-1){1'b0}}, mode};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        nal_model.codec_mode = mode;
        mode_writes++;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_random_unit();
        int kind;
        int cut;
        int payload;
        int n;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            cut = $urandom_range(0, 11);
            repeat ($urandom_range(2, 4)) send_byte(8'h00, 1'b0);
            send_byte(nalsplit_pkg::START_CODE_LAST, cut == 0);
            if (cut == 0) return;
            send_byte(8'($urandom_range(0, 255)), cut == 1);
            if (cut == 1) return;
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            payload = $urandom_range((cut == 2) ? 1 : 0, 10);
            for (n = 0; n < payload; n++) begin
                b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
                send_byte(b, (cut == 2) && (n == payload - 1));
            end
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 2))
                    0: b = 8'h00;
                    1: b = nalsplit_pkg::START_CODE_LAST;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b, $urandom_range(0, 19) == 0);
            end
        end else begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        int phase;
        int chunk;
        int target;
        in_bus.valid = 1'b0;
        in_bus.data_byte = '0;
        in_bus.stream_end = 1'b0;
        out_bus.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 50;
        mode_writes = 0;
        nal_model = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Four-byte start code, full type mask, and a stream end that closes a start code.
        write_codec_mode(nalsplit_pkg::CODEC_H264);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h65, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        // Streams too short to hold a start code, then a header cut off by the end.
        send_byte(8'hab, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        // HEVC headers with every bit set, and one whose second byte is missing.
        write_codec_mode(nalsplit_pkg::CODEC_HEVC);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b1);

        // Mode writes between chunks also land in the middle of open streams.
        target = nal_model.bytes_taken;
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 76 : 0;
            recv_stall_pct = (phase == 0) ? 76 : (phase == 1) ? 26 : 0;
            for (chunk = 0; chunk < 4; chunk++) begin
                write_codec_mode(((chunk + phase) % 2 == 0) ? nalsplit_pkg::CODEC_H264
                                                             : nalsplit_pkg::CODEC_HEVC);
                target += 50;
                while (nal_model.bytes_taken < target) send_random_unit();
            end
        end

        wait_all_nals();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d stream bytes over %0d stream ends, %0d NAL records checked,",
                 nal_model.bytes_taken, nal_model.streams_ended, nal_model.nals_checked);
        $display("%0d codec mode writes and %0d mismatches.", mode_writes, nal_model.mismatches);
        if (nal_model.mismatches == 0 && nal_model.expected_nals.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d NAL records still expected.",
                 nal_model.expected_nals.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
sv/nalsplit_pkg.sv
sv/nalsplit_if.sv
sv/annexb_nal_unit_splitter.sv
sim/testbench.sv
